### hdl/spm_pkg.sv
// Shared types, constants and helper functions for the stereo peak maximizer.
// Has no dependencies; every other file but spm_ram uses it by scoped names.
package spm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int DELAY_DEPTH = 32;
    localparam int KNEE_BITS = 24;
    localparam int DECAY_BITS = 5;
    localparam int DELAY_BITS = 4;
    localparam int RECIP_BITS = 14;
    localparam int RECIP_FRAC = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KNEE_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_SAMPLES = 2'd1;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [DECAY_BITS-1:0] DECAY_MIN = 5'd5;
    localparam logic [DECAY_BITS-1:0] DECAY_MAX = 5'd30;
    localparam logic [KNEE_BITS-1:0] KNEE_RESET = {1'b1, {(KNEE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          clipped;
    } out_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   clip;
    } div_res_t;

    function automatic logic [SAMPLE_BITS-1:0] abs_sample(input logic [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] r;
        r = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
        return r;
    endfunction

    function automatic logic [DECAY_BITS-1:0] clamp_decay(input logic [DECAY_BITS-1:0] d);
        logic [DECAY_BITS-1:0] r;
        r = d;
        if (d < DECAY_MIN)
        begin
            r = DECAY_MIN;
        end
        if (d > DECAY_MAX)
        begin
            r = DECAY_MAX;
        end
        return r;
    endfunction

    // Reciprocal of the decay time in Q0.16, rounded to nearest.
    function automatic logic [RECIP_BITS-1:0] recip_q16(input logic [DECAY_BITS-1:0] d);
        logic [RECIP_BITS-1:0] r;
        case (d)
            5'd5:    r = 14'd13107;
            5'd6:    r = 14'd10923;
            5'd7:    r = 14'd9362;
            5'd8:    r = 14'd8192;
            5'd9:    r = 14'd7282;
            5'd10:   r = 14'd6554;
            5'd11:   r = 14'd5958;
            5'd12:   r = 14'd5461;
            5'd13:   r = 14'd5041;
            5'd14:   r = 14'd4681;
            5'd15:   r = 14'd4369;
            5'd16:   r = 14'd4096;
            5'd17:   r = 14'd3855;
            5'd18:   r = 14'd3641;
            5'd19:   r = 14'd3449;
            5'd20:   r = 14'd3277;
            5'd21:   r = 14'd3121;
            5'd22:   r = 14'd2979;
            5'd23:   r = 14'd2849;
            5'd24:   r = 14'd2731;
            5'd25:   r = 14'd2621;
            5'd26:   r = 14'd2521;
            5'd27:   r = 14'd2427;
            5'd28:   r = 14'd2341;
            5'd29:   r = 14'd2260;
            5'd30:   r = 14'd2185;
            default: r = 14'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/spm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies.
module spm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/spm_env.sv
// Peak envelope tracker with a bit-serial shift-and-add multiplier for the decay step.
// Depends on spm_pkg for widths and the reciprocal table.
module spm_env (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [spm_pkg::SAMPLE_BITS-1:0]      peak,
    input  logic [spm_pkg::DECAY_BITS-1:0]       decay,
    output logic                                 done,
    output logic [spm_pkg::SAMPLE_BITS-1:0]      envelope
);

    localparam int SB = spm_pkg::SAMPLE_BITS;
    localparam int RB = spm_pkg::RECIP_BITS;
    localparam int PW = SB + RB;
    localparam int CW = $clog2(RB + 1);

    logic [SB-1:0] env_reg, env_next;
    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [RB-1:0] mplier_reg, mplier_next;
    logic [PW:0]   rounded;
    logic [SB-1:0] step;

    assign rounded = {1'b0, acc_reg} + (PW+1)'(1 << (spm_pkg::RECIP_FRAC - 1));
    assign step    = SB'(rounded >> spm_pkg::RECIP_FRAC);

    always_comb
    begin
        env_next    = env_reg;
        busy_next   = busy_reg;
        fin_next    = 1'b0;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            if (peak > env_reg)
            begin
                env_next  = peak;
                done_next = 1'b1;
            end
            else
            begin
                acc_next    = '0;
                mcand_next  = PW'(env_reg - peak);
                mplier_next = spm_pkg::recip_q16(spm_pkg::clamp_decay(decay));
                cnt_next    = CW'(RB);
                busy_next   = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            env_next  = env_reg - step;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            env_reg  <= env_next;
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done     = done_reg;
    assign envelope = env_reg;

endmodule

### hdl/spm_div.sv
// Bit-serial restoring divider that scales one sample by the gain divisor and saturates.
// Depends on spm_pkg for the sample width and the result struct.
module spm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [spm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [spm_pkg::SAMPLE_BITS-1:0] divisor,
    output logic                            done,
    output spm_pkg::div_res_t               res
);

    localparam int SB = spm_pkg::SAMPLE_BITS;
    localparam int CW = $clog2(SB + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SB-1:0] rem_reg, rem_next;
    logic [SB-1:0] shf_reg, shf_next;
    logic [SB-1:0] div_reg, div_next;
    logic          neg_reg, neg_next;
    logic          sat_reg, sat_next;
    logic [SB-1:0] mag;
    logic [SB:0]   trial;
    logic [SB-1:0] diff;
    logic          ge;
    logic          clip;

    // The numerator is mag * 2^(SB-1) + divisor / 2; its upper part starts the remainder
    // and its lower part is shifted in one bit per cycle.
    assign mag   = spm_pkg::abs_sample(sample);
    assign trial = {rem_reg, shf_reg[SB-1]};
    assign diff  = trial[SB-1:0] - div_reg;
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            rem_next  = {1'b0, mag[SB-1:1]};
            shf_next  = {mag[0], divisor[SB-1:1]};
            div_next  = divisor;
            neg_next  = sample[SB-1];
            sat_next  = {1'b0, mag[SB-1:1]} >= divisor;
            cnt_next  = CW'(SB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : trial[SB-1:0];
            shf_next = {shf_reg[SB-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
    end

    // Negative results may reach full scale exactly; positive ones stop one below it.
    always_comb
    begin
        if (neg_reg)
        begin
            clip      = sat_reg | (shf_reg[SB-1] & (|shf_reg[SB-2:0]));
            res.value = clip ? {1'b1, {(SB-1){1'b0}}} : (~shf_reg + 1'b1);
        end
        else
        begin
            clip      = sat_reg | shf_reg[SB-1];
            res.value = clip ? {1'b0, {(SB-1){1'b1}}} : shf_reg;
        end
        res.clip = clip;
    end

    assign done = done_reg;

endmodule

### hdl/stereo_peak_maximizer.sv
// Stereo peak maximizer: envelope, lookahead delay and per-channel normalizing division.
// A rising peak loads the envelope directly; a decaying one runs the 14-step serial decay
// multiply first. The 24-step serial divide follows, and a new request is taken only once
// the result is registered, which waits while the output holds a result not yet taken.
// Reset (rst_n, asynchronous) clears the envelope, write position and fill count;
// delay entries not yet written since reset read as zero.
module stereo_peak_maximizer #(
    parameter int DELAY_DEPTH = spm_pkg::DELAY_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  spm_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output spm_pkg::out_t                      out_data,
    input  logic                               cfg_we,
    input  logic [spm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [spm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SB = spm_pkg::SAMPLE_BITS;
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = $clog2(DELAY_DEPTH + 1);
    localparam int DB = spm_pkg::DELAY_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ENV  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [spm_pkg::KNEE_BITS-1:0]   knee_reg, knee_next;
    logic [spm_pkg::DECAY_BITS-1:0]  decay_reg, decay_next;
    logic [AW-1:0]                   wp_reg, wp_next;
    logic [FW-1:0]                   fill_reg, fill_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic                            out_valid_reg, out_valid_next;
    spm_pkg::out_t                   out_data_reg, out_data_next;

    logic                            accept;
    logic [SB-1:0]                   abs_l, abs_r, peak;
    logic [spm_pkg::DECAY_BITS-1:0]  decay_c;
    logic [DB-1:0]                   delay;
    logic [AW:0]                     rpos_wrap;
    logic [AW-1:0]                   rpos;
    logic [2*SB-1:0]                 ram_rdata;
    logic [SB-1:0]                   smp_l, smp_r;
    logic [SB-1:0]                   knee_c, divisor;
    logic                            env_done;
    logic [SB-1:0]                   env_val;
    logic                            div_start;
    logic                            done_l, done_r;
    spm_pkg::div_res_t               res_l, res_r;
    logic                            load_out;

    assign accept = in_valid & in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign abs_l = spm_pkg::abs_sample(in_data.left_in);
    assign abs_r = spm_pkg::abs_sample(in_data.right_in);
    assign peak  = (abs_l > abs_r) ? abs_l : abs_r;

    assign decay_c   = spm_pkg::clamp_decay(decay_reg);
    assign delay     = DB'(({1'b0, decay_c} + 6'd1) >> 1);
    assign rpos_wrap = {1'b0, wp_reg} + (AW+1)'(DELAY_DEPTH) - (AW+1)'(delay);
    assign rpos      = (wp_reg >= AW'(delay)) ? (wp_reg - AW'(delay)) : rpos_wrap[AW-1:0];

    spm_ram #(
        .WIDTH(2 * SB),
        .DEPTH(DELAY_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (accept),
        .waddr(wp_reg),
        .wdata({in_data.left_in, in_data.right_in}),
        .re   (accept),
        .raddr(rpos),
        .rdata(ram_rdata)
    );

    assign smp_l = rd_valid_reg ? ram_rdata[2*SB-1:SB] : '0;
    assign smp_r = rd_valid_reg ? ram_rdata[SB-1:0] : '0;

    spm_env u_env (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .peak    (peak),
        .decay   (decay_reg),
        .done    (env_done),
        .envelope(env_val)
    );

    always_comb
    begin
        knee_c = SB'(knee_reg);
        if (knee_reg == '0)
        begin
            knee_c = SB'(1);
        end
        else if (SB'(knee_reg) > spm_pkg::FULL_SCALE)
        begin
            knee_c = spm_pkg::FULL_SCALE;
        end
    end

    assign divisor   = (env_val > knee_c) ? env_val : knee_c;
    assign div_start = (state_reg == S_ENV) & env_done;

    spm_div u_div_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .sample (smp_l),
        .divisor(divisor),
        .done   (done_l),
        .res    (res_l)
    );

    spm_div u_div_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .sample (smp_r),
        .divisor(divisor),
        .done   (done_r),
        .res    (res_r)
    );

    assign load_out = (state_reg == S_OUT) & (~out_valid_reg | out_ready);

    always_comb
    begin
        state_next     = state_reg;
        knee_next      = knee_reg;
        decay_next     = decay_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                spm_pkg::REG_KNEE_LEVEL:    knee_next  = cfg_data[spm_pkg::KNEE_BITS-1:0];
                spm_pkg::REG_DECAY_SAMPLES: decay_next = cfg_data[spm_pkg::DECAY_BITS-1:0];
                default:                    ;
            endcase
        end

        if (out_valid_reg & out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // The entry read back was written since reset only if enough frames
                    // have gone in; otherwise it stands for the cleared line.
                    rd_valid_next = (fill_reg >= FW'(delay));
                    if (fill_reg != FW'(DELAY_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    wp_next    = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : (wp_reg + 1'b1);
                    state_next = S_ENV;
                end
            end
            S_ENV:
            begin
                if (env_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (done_l & done_r)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_data_next.left_out  = res_l.value;
                    out_data_next.right_out = res_r.value;
                    out_data_next.clipped   = res_l.clip | res_r.clip;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            knee_reg      <= spm_pkg::KNEE_RESET;
            decay_reg     <= spm_pkg::DECAY_MAX;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            knee_reg      <= knee_next;
            decay_reg     <= decay_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_accept_to_env: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_ENV))
        else $error("accepted request did not start the envelope phase");

    a_env_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        env_done |-> (state_reg == S_ENV))
        else $error("envelope finished outside its phase");

    a_div_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        done_l |-> (state_reg == S_DIV))
        else $error("divider finished outside its phase");

    a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done_l == done_r)
        else $error("left and right dividers out of step");

    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_val <= spm_pkg::FULL_SCALE)
        else $error("envelope above full scale");
`endif

endmodule

### sim/tb_stereo_peak_maximizer.sv
// Self-checking testbench for stereo_peak_maximizer: directed frames, then random
// audio-like bursts under several knee and decay settings, against a built-in predictor.
// Depends on spm_pkg and the stereo_peak_maximizer top level only.
module tb_stereo_peak_maximizer;

    localparam int DIRECTED_ROWS = 20;
    localparam int PHASES = 7;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLDOFF_AT = 150;
    localparam int HAW = $clog2(spm_pkg::DELAY_DEPTH);
    localparam logic [spm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [spm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic        known;
        logic [23:0] left_exp;
        logic [23:0] right_exp;
        logic        clip_exp;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    spm_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    spm_pkg::out_t out_data;
    logic cfg_we;
    logic [spm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [spm_pkg::CFG_DATA_BITS-1:0] cfg_data;

    logic [23:0] hist_left [spm_pkg::DELAY_DEPTH];
    logic [23:0] hist_right [spm_pkg::DELAY_DEPTH];
    logic [HAW-1:0] hist_pos;
    logic [23:0] env_level;
    logic [23:0] knee_setting;
    logic [4:0] decay_setting;

    spm_pkg::out_t pending_frames [$];
    probe_t directed_rows [DIRECTED_ROWS];
    int frames_sent = 0;
    int frames_checked = 0;
    int clipped_seen = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    int holdoff_left = 0;
    int stall_run = 0;
    int stall_mode = 0;
    bit holdoff_done = 1'b0;

    stereo_peak_maximizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [23:0] sample_magnitude(input logic [23:0] s);
        return s[23] ? ~s + 24'd1 : s;
    endfunction

    function automatic logic [23:0] scaled_sample(input int unsigned amp);
        logic [23:0] s;
        s = 24'($urandom_range(0, amp));
        return $urandom_range(0, 1) ? ~s + 24'd1 : s;
    endfunction

    function automatic spm_pkg::div_res_t divide_sample(input logic [23:0] raw,
                                                         input logic [23:0] divisor);
        spm_pkg::div_res_t res;
        logic [63:0] q;
        q = (64'(sample_magnitude(raw)) * 64'h800000 + 64'(divisor) / 64'd2) / 64'(divisor);
        res.clip = 1'b0;
        if (raw[23])
        begin
            if (q > 64'h800000)
            begin
                q = 64'h800000;
                res.clip = 1'b1;
            end
            res.value = 24'(~q + 64'd1);
        end
        else
        begin
            if (q > 64'h7FFFFF)
            begin
                q = 64'h7FFFFF;
                res.clip = 1'b1;
            end
            res.value = 24'(q);
        end
        return res;
    endfunction

    function automatic spm_pkg::out_t normalize_frame(input spm_pkg::in_t f);
        spm_pkg::out_t r;
        spm_pkg::div_res_t lq;
        spm_pkg::div_res_t rq;
        logic [23:0] lmag;
        logic [23:0] rmag;
        logic [23:0] peak;
        logic [23:0] knee;
        logic [23:0] divisor;
        logic [63:0] fall;
        int unsigned d;
        int unsigned recip;
        int unsigned delay;
        logic [HAW-1:0] rpos;
        lmag = sample_magnitude(f.left_in);
        rmag = sample_magnitude(f.right_in);
        peak = (lmag > rmag) ? lmag : rmag;
        d = 32'(decay_setting);
        if (d < 32'(spm_pkg::DECAY_MIN))
        begin
            d = 32'(spm_pkg::DECAY_MIN);
        end
        if (d > 32'(spm_pkg::DECAY_MAX))
        begin
            d = 32'(spm_pkg::DECAY_MAX);
        end
        recip = (65536 + d / 2) / d;
        if (peak > env_level)
        begin
            env_level = peak;
        end
        else
        begin
            fall = (64'(env_level - peak) * 64'(recip) + 64'd32768) >> 16;
            env_level = env_level - 24'(fall);
        end
        knee = knee_setting;
        if (knee == 24'd0)
        begin
            knee = 24'd1;
        end
        if (knee > spm_pkg::FULL_SCALE)
        begin
            knee = spm_pkg::FULL_SCALE;
        end
        divisor = (env_level > knee) ? env_level : knee;
        delay = (d + 1) / 2;
        hist_left[hist_pos] = f.left_in;
        hist_right[hist_pos] = f.right_in;
        rpos = HAW'((32'(hist_pos) + spm_pkg::DELAY_DEPTH - delay) % spm_pkg::DELAY_DEPTH);
        lq = divide_sample(hist_left[rpos], divisor);
        rq = divide_sample(hist_right[rpos], divisor);
        r.left_out = lq.value;
        r.right_out = rq.value;
        r.clipped = lq.clip | rq.clip;
        hist_pos = HAW'((32'(hist_pos) + 1) % spm_pkg::DELAY_DEPTH);
        return r;
    endfunction

    task automatic offer_frame(input spm_pkg::in_t f, input bit known,
                               input spm_pkg::out_t typed);
        spm_pkg::out_t predicted;
        int gap;
        in_valid <= 1'b1;
        in_data <= f;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = normalize_frame(f);
        pending_frames.push_back(known ? typed : predicted);
        frames_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [spm_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == spm_pkg::REG_KNEE_LEVEL)
        begin
            knee_setting = val;
        end
        else if (idx == spm_pkg::REG_DECAY_SAMPLES)
        begin
            decay_setting = val[4:0];
        end
    endtask

    // Every accepted result is matched against the oldest outstanding request.
    always @(posedge clk)
    begin : collect_results
        spm_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got L=%0d R=%0d clip=%0b",
                         $time, out_data.left_out, out_data.right_out, out_data.clipped);
            end
            else
            begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (want.clipped)
                begin
                    clipped_seen++;
                end
                if (out_data.left_out !== want.left_out)
                begin
                    mismatch_count++;
                    $display("%0t: left_out expected %0d, got %0d",
                             $time, want.left_out, out_data.left_out);
                end
                if (out_data.right_out !== want.right_out)
                begin
                    mismatch_count++;
                    $display("%0t: right_out expected %0d, got %0d",
                             $time, want.right_out, out_data.right_out);
                end
                if (out_data.clipped !== want.clipped)
                begin
                    mismatch_count++;
                    $display("%0t: clipped expected %0b, got %0b",
                             $time, want.clipped, out_data.clipped);
                end
            end
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else if (!holdoff_done && frames_checked >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_run = $urandom_range(5, 60);
            end
            stall_run--;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) != 0);
                2: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        spm_pkg::in_t frame;
        spm_pkg::out_t typed;
        int remaining;
        int pattern;
        int run_len;
        int unsigned peak_amp;
        int unsigned tail_amp;
        logic [23:0] knee_val;
        logic [23:0] decay_val;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hist_left = '{default: '0};
        hist_right = '{default: '0};
        hist_pos = '0;
        env_level = '0;
        knee_setting = spm_pkg::KNEE_RESET;
        decay_setting = 5'd30;

        // With the reset decay the lookahead is 15 frames, so the first outputs come
        // from the cleared delay stores and must be silent.
        directed_rows = '{
            {24'h7FFFFF, 24'h7FFFFF, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h800000, 24'h800000, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h000000, 24'h000000, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'hFFFFFF, 24'h000001, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h7FFFFF, 24'h800000, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h800000, 24'h000000, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h000001, 24'hFFFFFF, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h555555, 24'hAAAAAA, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'hAAAAAA, 24'h555555, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h400000, 24'hC00000, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h000064, 24'hFFFF9C, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h000000, 24'h7FFFFF, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h800001, 24'h000000, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h003039, 24'hFF2BCF, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h000007, 24'hFFFFF9, 1'b1, 24'h0, 24'h0, 1'b0},
            {24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0, 1'b0},
            {24'h7FFFFF, 24'h000001, 1'b0, 24'h0, 24'h0, 1'b0},
            {24'hFFFFFE, 24'h000002, 1'b0, 24'h0, 24'h0, 1'b0},
            {24'h000000, 24'h800000, 1'b0, 24'h0, 24'h0, 1'b0},
            {24'h3FFFFF, 24'hBFFFFF, 1'b0, 24'h0, 24'h0, 1'b0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            frame.left_in = directed_rows[i].left;
            frame.right_in = directed_rows[i].right;
            typed.left_out = directed_rows[i].left_exp;
            typed.right_out = directed_rows[i].right_exp;
            typed.clipped = directed_rows[i].clip_exp;
            offer_frame(frame, directed_rows[i].known, typed);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                in_valid <= 1'b0;
                while (pending_frames.size() != 0)
                begin
                    @(posedge clk);
                end
                case (p)
                    1:
                    begin
                        knee_val = 24'd1;
                        decay_val = 24'd5;
                    end
                    2:
                    begin
                        knee_val = 24'd0;
                        decay_val = 24'd0;
                    end
                    3:
                    begin
                        knee_val = 24'hFFFFFF;
                        decay_val = 24'hFFFFFF;
                    end
                    4:
                    begin
                        knee_val = 24'h800000;
                        decay_val = 24'd30;
                    end
                    5:
                    begin
                        knee_val = 24'($urandom_range(1, 65536));
                        decay_val = (24'($urandom) & 24'hFFFFE0) | 24'($urandom_range(5, 30));
                    end
                    default:
                    begin
                        knee_val = 24'($urandom_range(1, 8388608));
                        decay_val = (24'($urandom) & 24'hFFFFE0) | 24'($urandom_range(5, 30));
                    end
                endcase
                write_reg(spm_pkg::REG_KNEE_LEVEL, knee_val);
                write_reg(spm_pkg::REG_DECAY_SAMPLES, decay_val);
                if (p == 4)
                begin
                    write_reg(REG_SPARE_2, 24'($urandom));
                    write_reg(REG_SPARE_3, 24'($urandom));
                end
                cfg_we <= 1'b0;
            end

            // Mostly transients followed by a quieter tail, so the envelope is seen
            // attacking and then decaying across the lookahead window.
            remaining = (p == 0) ? 40 : 57;
            while (remaining > 0)
            begin
                pattern = $urandom_range(0, 9);
                peak_amp = 32'h7FFFFF >> $urandom_range(0, 10);
                tail_amp = peak_amp >> $urandom_range(1, 16);
                run_len = (pattern < 2) ? $urandom_range(1, 6) : $urandom_range(2, 40);
                for (int k = 0; k < run_len && remaining > 0; k++)
                begin
                    if (pattern < 2)
                    begin
                        frame.left_in = 24'($urandom);
                        frame.right_in = 24'($urandom);
                    end
                    else if (pattern < 8)
                    begin
                        if (k == 0)
                        begin
                            frame.left_in = scaled_sample(peak_amp);
                            frame.right_in = scaled_sample(peak_amp);
                            if ($urandom_range(0, 3) == 0)
                            begin
                                frame.right_in = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                            end
                        end
                        else
                        begin
                            frame.left_in = scaled_sample(tail_amp);
                            frame.right_in = scaled_sample(tail_amp);
                        end
                    end
                    else
                    begin
                        frame.left_in = scaled_sample(2);
                        frame.right_in = scaled_sample(2);
                    end
                    offer_frame(frame, 1'b0, '0);
                    remaining--;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);

        $display("Covered %0d frames (%0d directed) over %0d register settings, %0d clipped.",
                 frames_sent, DIRECTED_ROWS, PHASES, clipped_seen);
        $display("The output side was held off for %0d cycles with requests still arriving.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
